/* hdl/crc8fr_pkg.sv */
// shared types, constants and crc function for the crc8 frame receiver
package crc8fr_pkg;

   // frame limits and crc polynomial (reflected maxim form)
   localparam int unsigned MAX_PAYLOAD   = 4;
   localparam int unsigned LEN_WIDTH     = 3;
   localparam int unsigned PAYLOAD_WIDTH = 32;
   localparam int unsigned CSR_IDX_WIDTH = 8;
   localparam logic [7:0]  CRC_POLY      = 8'h8C;
   localparam logic [7:0]  START_RESET   = 8'h05;
   localparam logic [7:0]  END_RESET     = 8'h0A;

   // register indexes on the csr port
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_START_MARKER = CSR_IDX_WIDTH'(0);
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_END_MARKER   = CSR_IDX_WIDTH'(1);

   // decoder phases
   typedef enum logic [2:0] {
      PH_HUNT = 3'd0,
      PH_LEN  = 3'd1,
      PH_DATA = 3'd2,
      PH_CRC  = 3'd3,
      PH_END  = 3'd4
   } phase_type;

   // frame status codes
   typedef enum logic [1:0] {
      ST_GOOD    = 2'd0,
      ST_CRC_ERR = 2'd1,
      ST_BAD_LEN = 2'd2
   } status_type;

   // result of one byte step
   typedef struct packed {
      logic                     hit;
      status_type               status;
      logic [PAYLOAD_WIDTH-1:0] payload;
      logic [LEN_WIDTH-1:0]     length;
   } result_type;

   // bytewise reflected crc8 update, lsb first
   function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] data);
      logic [7:0] c;
      logic       fb;
      c = crc;
      for (int k = 0; k < 8; k++) begin
         fb = c[0] ^ data[k];
         c  = {1'b0, c[7:1]};
         if (fb) begin
            c = c ^ CRC_POLY;
         end
      end
      return c;
   endfunction

endpackage

/* hdl/crc8fr_decode.sv */
// frame phase tracking, running crc and result generation for one byte per step
module crc8fr_decode (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    step_en,
   input  logic [7:0]              rx_byte,
   input  logic [7:0]              start_marker,
   input  logic [7:0]              end_marker,
   output crc8fr_pkg::result_type  result
);
   import crc8fr_pkg::*;

   phase_type                phase_ff, phase_in;
   logic [LEN_WIDTH-1:0]     exp_len_ff, exp_len_in;
   logic [LEN_WIDTH-1:0]     seen_ff, seen_in;
   logic [7:0]               crc_ff, crc_in;
   logic [PAYLOAD_WIDTH-1:0] shift_ff, shift_in;
   logic [7:0]               rx_crc_ff, rx_crc_in;
   logic [7:0]               crc_next;
   logic [LEN_WIDTH:0]       seen_inc;

   // crc seed is zero when a frame opens
   assign crc_next = crc8_update((phase_ff == PH_HUNT) ? 8'h00 : crc_ff, rx_byte);
   assign seen_inc = {1'b0, seen_ff} + (LEN_WIDTH+1)'(1);

   // next state and result for the current byte
   always_comb begin
      phase_in   = phase_ff;
      exp_len_in = exp_len_ff;
      seen_in    = seen_ff;
      crc_in     = crc_ff;
      shift_in   = shift_ff;
      rx_crc_in  = rx_crc_ff;
      result     = '0;
      unique case (phase_ff)
         PH_HUNT: begin
            if (rx_byte == start_marker) begin
               crc_in     = crc_next;
               shift_in   = '0;
               seen_in    = '0;
               exp_len_in = '0;
               phase_in   = PH_LEN;
            end
         end
         PH_LEN: begin
            if (rx_byte == 8'h00 || rx_byte > 8'(MAX_PAYLOAD)) begin
               phase_in      = PH_HUNT;
               result.hit    = 1'b1;
               result.status = ST_BAD_LEN;
            end else begin
               exp_len_in = rx_byte[LEN_WIDTH-1:0];
               crc_in     = crc_next;
               seen_in    = '0;
               phase_in   = PH_DATA;
            end
         end
         PH_DATA: begin
            shift_in = {shift_ff[PAYLOAD_WIDTH-9:0], rx_byte};
            crc_in   = crc_next;
            seen_in  = seen_inc[LEN_WIDTH-1:0];
            if (seen_inc >= {1'b0, exp_len_ff}) begin
               phase_in = PH_CRC;
            end
         end
         PH_CRC: begin
            rx_crc_in = rx_byte;
            phase_in  = PH_END;
         end
         PH_END: begin
            if (rx_byte == end_marker) begin
               result.hit     = 1'b1;
               result.status  = (crc_ff == rx_crc_ff) ? ST_GOOD : ST_CRC_ERR;
               result.payload = shift_ff;
               result.length  = exp_len_ff;
               phase_in       = PH_HUNT;
            end
         end
         default: begin
            phase_in = PH_HUNT;
         end
      endcase
   end

   // state registers advance only on a processed byte
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_HUNT;
         exp_len_ff <= '0;
         seen_ff    <= '0;
         crc_ff     <= '0;
         shift_ff   <= '0;
         rx_crc_ff  <= '0;
      end else if (step_en) begin
         phase_ff   <= phase_in;
         exp_len_ff <= exp_len_in;
         seen_ff    <= seen_in;
         crc_ff     <= crc_in;
         shift_ff   <= shift_in;
         rx_crc_ff  <= rx_crc_in;
      end
   end

   // a bad length result never carries payload
   a_bad_len_empty: assert property (@(posedge clock) disable iff (reset)
      (result.hit && result.status == ST_BAD_LEN) |-> (result.payload == '0 && result.length == '0))
      else $error("bad length result carries payload");

   // every reported frame sends the decoder back to hunting
   a_hunt_after_result: assert property (@(posedge clock) disable iff (reset)
      (step_en && result.hit) |=> (phase_ff == PH_HUNT))
      else $error("decoder not hunting after a result");

   // the byte counter is cleared before payload collection starts
   a_len_count_clear: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_LEN) |-> (seen_ff == '0))
      else $error("byte count not cleared in length phase");

   // every frame reported with a good or crc error status has a legal length
   a_good_len_range: assert property (@(posedge clock) disable iff (reset)
      (result.hit && result.status != ST_BAD_LEN) |->
         (result.length != '0 && {1'b0, result.length} <= (LEN_WIDTH+1)'(MAX_PAYLOAD)))
      else $error("frame reported with illegal length");

endmodule

/* hdl/crc8_frame_receiver.sv */
// top level of the crc8 frame receiver: input register, decoder, result register, csr
//
// Usage:
//   req_*  : one received byte per transfer (req_rx_byte). A transfer happens on a
//            rising edge with req_valid high and req_stall low.
//   rsp_*  : one result per completed frame: rsp_frame_status (0 good, 1 crc
//            mismatch, 2 bad length), rsp_payload (first byte most significant)
//            and rsp_payload_length. Taken when rsp_valid is high and rsp_stall low.
//   csr_*  : marker writes, index 0 start marker, index 1 end marker; csr_ready is
//            always high. Other indexes are dropped.
//   Path: a byte that closes a frame goes from the input register through the
//   decoder logic into the result register, where its result shows.
//   Throughput: one byte per cycle while rsp_stall does not hold a result; the crc
//   update and phase logic sit in the single stage between the two registers.
//   Reset: markers return to 0x05 and 0x0A, the decoder hunts for a start marker,
//   both registers are emptied.
//   Stall: while rsp_stall holds a result, one more byte may wait in the input
//   register; after that req_stall rises until the result is taken.
module crc8_frame_receiver (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic [7:0]                             req_rx_byte,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic [1:0]                             rsp_frame_status,
   output logic [crc8fr_pkg::PAYLOAD_WIDTH-1:0]   rsp_payload,
   output logic [crc8fr_pkg::LEN_WIDTH-1:0]       rsp_payload_length,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [crc8fr_pkg::CSR_IDX_WIDTH-1:0]   csr_index,
   input  logic [7:0]                             csr_wdata
);
   import crc8fr_pkg::*;

   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;
   logic       out_valid_ff, out_valid_in;
   result_type out_ff;
   result_type step_result;
   logic [7:0] start_marker_ff;
   logic [7:0] end_marker_ff;
   logic       step;
   logic       req_xfer;

   // a byte is processed when the result register is free or being drained
   assign step      = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !step;
   assign req_xfer  = req_valid && !req_stall;
   assign csr_ready = 1'b1;

   // input register
   assign in_valid_in = req_xfer ? 1'b1 : (step ? 1'b0 : in_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         in_byte_ff <= req_rx_byte;
      end
   end

   // marker registers
   always_ff @(posedge clock) begin
      if (reset) begin
         start_marker_ff <= START_RESET;
         end_marker_ff   <= END_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_START_MARKER: start_marker_ff <= csr_wdata;
            CSR_END_MARKER:   end_marker_ff   <= csr_wdata;
            default: ;
         endcase
      end
   end

   // frame decoder
   crc8fr_decode u_decode (
      .clock        (clock),
      .reset        (reset),
      .step_en      (step),
      .rx_byte      (in_byte_ff),
      .start_marker (start_marker_ff),
      .end_marker   (end_marker_ff),
      .result       (step_result)
   );

   // result register
   assign out_valid_in = (step && step_result.hit) ? 1'b1 :
                         (rsp_stall ? out_valid_ff : 1'b0);

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step && step_result.hit) begin
         out_ff <= step_result;
      end
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_frame_status   = out_ff.status;
   assign rsp_payload        = out_ff.payload;
   assign rsp_payload_length = out_ff.length;

endmodule

/* bench/crc8_frame_receiver_check.sv */
// checker for the crc8 frame receiver: follows byte and csr transfers, predicts and compares frame reports
module crc8_frame_receiver_check (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   input  logic                                 req_stall,
   input  logic [7:0]                           req_rx_byte,
   input  logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   input  logic [1:0]                           rsp_frame_status,
   input  logic [crc8fr_pkg::PAYLOAD_WIDTH-1:0] rsp_payload,
   input  logic [crc8fr_pkg::LEN_WIDTH-1:0]     rsp_payload_length,
   input  logic                                 csr_valid,
   input  logic                                 csr_ready,
   input  logic [crc8fr_pkg::CSR_IDX_WIDTH-1:0] csr_index,
   input  logic [7:0]                           csr_wdata,
   output int                                   mismatch_count,
   output int                                   reports_due
);
   import crc8fr_pkg::*;

   typedef struct packed {
      status_type               status;
      logic [PAYLOAD_WIDTH-1:0] payload;
      logic [LEN_WIDTH-1:0]     length;
   } frame_report_type;

   // frame reports still owed by the block, oldest first
   frame_report_type         frame_reports[$];

   // decoder copy: markers and per-frame state
   logic [7:0]               open_marker;
   logic [7:0]               close_marker;
   phase_type                phase;
   logic [LEN_WIDTH-1:0]     want_len;
   logic [LEN_WIDTH-1:0]     got_len;
   logic [7:0]               crc_acc;
   logic [7:0]               crc_rx;
   logic [PAYLOAD_WIDTH-1:0] shift_acc;

   // reflected crc8: fold the byte in, then shift out eight bits
   function automatic logic [7:0] crc_next(input logic [7:0] crc, input logic [7:0] data);
      logic [7:0] c;
      c = crc ^ data;
      for (int k = 0; k < 8; k++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

   // advance the decoder by one received byte, queue any report it closes
   task automatic decode_byte(input logic [7:0] data);
      frame_report_type rep;
      case (phase)
         PH_HUNT: begin
            if (data == open_marker) begin
               crc_acc   = crc_next(8'h00, data);
               shift_acc = '0;
               got_len   = '0;
               want_len  = '0;
               phase     = PH_LEN;
            end
         end
         PH_LEN: begin
            if (data == 8'h00 || data > MAX_PAYLOAD) begin
               rep.status  = ST_BAD_LEN;
               rep.payload = '0;
               rep.length  = '0;
               frame_reports.push_back(rep);
               phase = PH_HUNT;
            end else begin
               want_len = data[LEN_WIDTH-1:0];
               crc_acc  = crc_next(crc_acc, data);
               got_len  = '0;
               phase    = PH_DATA;
            end
         end
         PH_DATA: begin
            shift_acc = {shift_acc[PAYLOAD_WIDTH-9:0], data};
            crc_acc   = crc_next(crc_acc, data);
            got_len   = got_len + 1'b1;
            if (got_len >= want_len) begin
               phase = PH_CRC;
            end
         end
         PH_CRC: begin
            crc_rx = data;
            phase  = PH_END;
         end
         PH_END: begin
            // anything but the closing marker is dropped here
            if (data == close_marker) begin
               rep.status  = (crc_acc == crc_rx) ? ST_GOOD : ST_CRC_ERR;
               rep.payload = shift_acc;
               rep.length  = want_len;
               frame_reports.push_back(rep);
               phase = PH_HUNT;
            end
         end
         default: begin
            phase = PH_HUNT;
         end
      endcase
   endtask

   // watch all three channels at each edge
   always @(posedge clock) begin
      frame_report_type due;
      if (reset) begin
         frame_reports.delete();
         open_marker  = START_RESET;
         close_marker = END_RESET;
         phase        = PH_HUNT;
         want_len     = '0;
         got_len      = '0;
         crc_acc      = '0;
         crc_rx       = '0;
         shift_acc    = '0;
      end else begin
         // marker writes; other indexes are dropped
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_START_MARKER) begin
               open_marker = csr_wdata;
            end else if (csr_index == CSR_END_MARKER) begin
               close_marker = csr_wdata;
            end
         end
         if (req_valid && !req_stall) begin
            decode_byte(req_rx_byte);
         end
         // compare each report transfer against the oldest prediction
         if (rsp_valid && !rsp_stall) begin
            if (frame_reports.size() == 0) begin
               $display("%0t: report expected none, actual status %0d payload %h length %0d",
                        $time, rsp_frame_status, rsp_payload, rsp_payload_length);
               mismatch_count++;
            end else begin
               due = frame_reports.pop_front();
               if (rsp_frame_status !== due.status) begin
                  $display("%0t: frame_status expected %0d, actual %0d", $time,
                           due.status, rsp_frame_status);
                  mismatch_count++;
               end
               if (rsp_payload !== due.payload) begin
                  $display("%0t: payload expected %h, actual %h", $time,
                           due.payload, rsp_payload);
                  mismatch_count++;
               end
               if (rsp_payload_length !== due.length) begin
                  $display("%0t: payload_length expected %0d, actual %0d", $time,
                           due.length, rsp_payload_length);
                  mismatch_count++;
               end
            end
         end
      end
      reports_due = frame_reports.size();
   end

endmodule

/* bench/crc8_frame_receiver_test.sv */
// testbench top for the crc8 frame receiver: clock, reset, byte and csr stimulus, verdict
module crc8_frame_receiver_test;
   import crc8fr_pkg::*;

   localparam int CLK_HALF       = 4;
   localparam int RESET_CYCLES   = 8;
   localparam int HOLD_CYCLES    = 60;
   localparam int SETTLE_CYCLES  = 4;
   localparam int BLOCK_BYTES    = 120;
   localparam int TIMEOUT_CYCLES = 400000;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_SPARE = CSR_IDX_WIDTH'(255);

   logic                       clock       = 1'b0;
   logic                       reset       = 1'b1;
   logic                       req_valid   = 1'b0;
   logic                       req_stall;
   logic [7:0]                 req_rx_byte = 8'h00;
   logic                       rsp_valid;
   logic                       rsp_stall   = 1'b0;
   logic [1:0]                 rsp_frame_status;
   logic [PAYLOAD_WIDTH-1:0]   rsp_payload;
   logic [LEN_WIDTH-1:0]       rsp_payload_length;
   logic                       csr_valid   = 1'b0;
   logic                       csr_ready;
   logic [CSR_IDX_WIDTH-1:0]   csr_index   = '0;
   logic [7:0]                 csr_wdata   = 8'h00;

   int                         mismatch_count;
   int                         reports_due;

   // traffic shaping shared with the receiver process
   int                         sender_idle_pct    = 24;
   int                         receiver_stall_pct = 82;
   int                         hold_requests      = 0;
   int                         hold_served        = 0;
   int                         hold_left          = 0;
   int                         bytes_sent         = 0;

   // current markers and the payload of the frame being built
   logic [7:0]                 open_marker  = START_RESET;
   logic [7:0]                 close_marker = END_RESET;
   logic [7:0]                 body_q[$];

   always begin
      #(CLK_HALF) clock = 1'b1;
      #(CLK_HALF) clock = 1'b0;
   end

   crc8_frame_receiver i_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_rx_byte        (req_rx_byte),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_frame_status   (rsp_frame_status),
      .rsp_payload        (rsp_payload),
      .rsp_payload_length (rsp_payload_length),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   crc8_frame_receiver_check i_check (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_rx_byte        (req_rx_byte),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_frame_status   (rsp_frame_status),
      .rsp_payload        (rsp_payload),
      .rsp_payload_length (rsp_payload_length),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .mismatch_count     (mismatch_count),
      .reports_due        (reports_due)
   );

   // report side: random stalls, or a long hold when one is requested
   always @(posedge clock) begin
      if (hold_requests != hold_served) begin
         hold_served = hold_requests;
         hold_left   = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
         hold_left = hold_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < receiver_stall_pct);
      end
   end

   // one byte transfer, after a random idle gap
   task automatic send_byte(input logic [7:0] data);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_rx_byte <= data;
      do @(posedge clock); while (req_stall);
      bytes_sent++;
   endtask

   // stop sending, wait for every report, then let the pipeline settle
   task automatic await_quiet();
      req_valid <= 1'b0;
      do @(posedge clock); while (reports_due != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // csr transfer; valid is left high for back-to-back writes
   task automatic write_reg(input logic [CSR_IDX_WIDTH-1:0] idx, input logic [7:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
   endtask

   task automatic program_markers(input logic [7:0] open_val, input logic [7:0] close_val);
      write_reg(CSR_START_MARKER, open_val);
      write_reg(CSR_END_MARKER, close_val);
      write_reg(CSR_SPARE, 8'($urandom));
      csr_valid    <= 1'b0;
      open_marker  = open_val;
      close_marker = close_val;
   endtask

   // reflected crc8, one data bit at a time
   function automatic logic [7:0] crc_step(input logic [7:0] crc, input logic [7:0] data);
      logic [7:0] c;
      logic       fb;
      c = crc;
      for (int k = 0; k < 8; k++) begin
         fb = c[0] ^ data[k];
         c  = c >> 1;
         if (fb) begin
            c = c ^ CRC_POLY;
         end
      end
      return c;
   endfunction

   // random payload, some bytes equal to the markers
   task automatic fill_body(input int count);
      int pick;
      body_q.delete();
      for (int k = 0; k < count; k++) begin
         pick = $urandom_range(9);
         if (pick == 0) begin
            body_q.push_back(open_marker);
         end else if (pick == 1) begin
            body_q.push_back(close_marker);
         end else begin
            body_q.push_back(8'($urandom));
         end
      end
   endtask

   // whole frame from body_q; bad lengths stop after the length byte
   task automatic send_frame(input logic [7:0] len_byte, input bit bad_crc, input int filler);
      logic [7:0] crc;
      logic [7:0] fill;
      send_byte(open_marker);
      send_byte(len_byte);
      if (len_byte == 8'h00 || len_byte > MAX_PAYLOAD) begin
         return;
      end
      crc = crc_step(crc_step(8'h00, open_marker), len_byte);
      foreach (body_q[k]) begin
         send_byte(body_q[k]);
         crc = crc_step(crc, body_q[k]);
      end
      if (bad_crc) begin
         crc = crc ^ 8'($urandom_range(255, 1));
      end
      send_byte(crc);
      // junk while waiting for the close marker, the open marker first
      for (int k = 0; k < filler; k++) begin
         fill = (k == 0) ? open_marker : 8'($urandom);
         if (fill == close_marker) begin
            fill = fill ^ 8'h01;
         end
         send_byte(fill);
      end
      send_byte(close_marker);
   endtask

   // mostly well-formed frames, with noise, bad lengths and cut-off frames
   task automatic run_block();
      int first;
      int pick;
      int len;
      first = bytes_sent;
      while (bytes_sent - first < BLOCK_BYTES) begin
         pick = $urandom_range(99);
         len  = $urandom_range(MAX_PAYLOAD, 1);
         if (pick < 8) begin
            repeat ($urandom_range(3, 1)) send_byte(8'($urandom));
         end else if (pick < 18) begin
            body_q.delete();
            send_frame($urandom_range(1) ? 8'h00 : 8'($urandom_range(255, MAX_PAYLOAD + 1)),
                       1'b0, 0);
         end else if (pick < 26) begin
            send_byte(open_marker);
            send_byte(8'(len));
            repeat ($urandom_range(len - 1, 0)) send_byte(8'($urandom));
         end else begin
            fill_body(len);
            send_frame(8'(len), $urandom_range(99) < 20,
                       ($urandom_range(99) < 25) ? $urandom_range(2, 1) : 0);
         end
      end
      await_quiet();
   endtask

   // stimulus and verdict
   initial begin
      logic [7:0] shared;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // directed: smallest and largest frames, markers as data, bad lengths, crc error
      body_q = '{8'h00};
      send_frame(8'd1, 1'b0, 0);
      body_q = '{open_marker, close_marker, 8'hFF, 8'h00};
      send_frame(8'(MAX_PAYLOAD), 1'b0, 0);
      body_q.delete();
      send_frame(8'h00, 1'b0, 0);
      send_frame(8'(MAX_PAYLOAD + 1), 1'b0, 0);
      send_frame(8'hFF, 1'b0, 0);
      body_q = '{8'h5A, 8'hA5};
      send_frame(8'd2, 1'b1, 2);

      // long report hold while bytes keep coming back to back
      sender_idle_pct = 0;
      hold_requests++;
      repeat (6) begin
         fill_body(1);
         send_frame(8'd1, 1'b0, 0);
      end
      await_quiet();

      // random blocks under changing markers and traffic
      for (int blk = 0; blk < 6; blk++) begin
         if (blk < 2) begin
            sender_idle_pct    = 24;
            receiver_stall_pct = 82;
         end else if (blk < 4) begin
            sender_idle_pct    = 82;
            receiver_stall_pct = 24;
         end else begin
            sender_idle_pct    = 0;
            receiver_stall_pct = 0;
         end
         shared = 8'($urandom);
         case (blk)
            0: program_markers(8'h00, 8'hFF);
            1: program_markers(8'hFF, 8'h00);
            3: program_markers(shared, shared);
            4: program_markers(START_RESET, END_RESET);
            default: program_markers(8'($urandom), 8'($urandom));
         endcase
         run_block();
      end

      if (mismatch_count == 0 && reports_due == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   // watchdog
   initial begin
      #(2 * CLK_HALF * TIMEOUT_CYCLES);
      $display("Verification failed");
      $finish;
   end

endmodule
